>>> rtl/triangle_tangent_basis_core_assert.svh
// ----------------------------------------------------------------------------
// triangle tangent basis assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH

// checked on every rising edge outside reset
`define TTB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define TTB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// widths, constants and shared types of the triangle tangent basis core
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int PosW      = 24;             // position, signed Q16.8
  localparam int TexW      = 16;             // texture coordinate, signed Q4.12
  localparam int IdxW      = 16;             // vertex index
  localparam int DpW       = PosW + 1;       // position delta
  localparam int DtW       = TexW + 1;       // texture coordinate delta
  localparam int ProdW     = DpW + DtW;      // one product
  localparam int NumW      = ProdW + 1;      // difference of two products
  localparam int DetW      = 2 * DtW + 1;    // uv determinant
  localparam int OutW      = 32;             // result, signed Q16.16
  localparam int QuotShift = 20;             // numerator scale before division
  localparam int DvdW      = 64;             // scaled dividend
  localparam int QuoW      = OutW + 1;       // quotient bits worked out
  localparam int CntW      = $clog2(QuoW);
  localparam int NumRes    = 6;              // tangent and bitangent components
  localparam int OpW       = 3;

  localparam logic [OutW-1:0] OutMax = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0] OutMin = 32'h8000_0000;

  typedef struct packed {
    logic                   start;
    logic signed [NumW-1:0] num;
    logic signed [DetW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [OutW-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/ttb_mul.sv
// ----------------------------------------------------------------------------
// ttb_mul
// shared signed multiplier, delta times delta, product registered
// ----------------------------------------------------------------------------
module ttb_mul (
  input  logic                           clk_i,
  input  logic signed [ttb_pkg::DpW-1:0] a_i,
  input  logic signed [ttb_pkg::DtW-1:0] b_i,
  output logic signed [ttb_pkg::ProdW-1:0] p_o
);

  logic signed [ttb_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ttb_pkg::ProdW'(a_i) * ttb_pkg::ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> rtl/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div
// restoring divider, one quotient bit per cycle, rounded and saturated
// ----------------------------------------------------------------------------
module ttb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttb_pkg::div_req_t req_i,
  output ttb_pkg::div_rsp_t rsp_o
);

  localparam logic [2:0] DIdle = 3'd0;
  localparam logic [2:0] DPrep = 3'd1;
  localparam logic [2:0] DLoad = 3'd2;
  localparam logic [2:0] DRun  = 3'd3;
  localparam logic [2:0] DFin  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic                        neg_q;
  logic [ttb_pkg::NumW-1:0]    un_q;
  logic [ttb_pkg::DetW-1:0]    ud_q;
  logic [ttb_pkg::DvdW-1:0]    dvd_q;
  logic                        ovf_q;
  logic [ttb_pkg::DetW-1:0]    rem_q;
  logic [ttb_pkg::QuoW-1:0]    quo_q;
  logic [ttb_pkg::CntW-1:0]    cnt_q;

  logic [ttb_pkg::DetW:0]      trial;
  logic [ttb_pkg::DetW:0]      diff;
  logic                        fits;
  logic                        pos_big;
  logic                        neg_big;
  logic [ttb_pkg::OutW-1:0]    quot;

  assign trial = {rem_q, quo_q[ttb_pkg::QuoW-1]};
  assign diff  = trial - {1'b0, ud_q};
  assign fits  = trial >= {1'b0, ud_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIdle: if (req_i.start) state_d = DPrep;
      DPrep: state_d = DLoad;
      DLoad: state_d = DRun;
      DRun:  if (cnt_q == ttb_pkg::CntW'(ttb_pkg::QuoW - 1)) state_d = DFin;
      DFin:  state_d = DIdle;
      default: state_d = DIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DLoad) begin
        cnt_q <= '0;
      end else if (state_q == DRun) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIdle: begin
        if (req_i.start) begin
          neg_q <= req_i.num[ttb_pkg::NumW-1] ^ req_i.den[ttb_pkg::DetW-1];
          un_q  <= req_i.num[ttb_pkg::NumW-1] ? ttb_pkg::NumW'(-req_i.num)
                                               : ttb_pkg::NumW'(req_i.num);
          ud_q  <= req_i.den[ttb_pkg::DetW-1] ? ttb_pkg::DetW'(-req_i.den)
                                               : ttb_pkg::DetW'(req_i.den);
        end
      end
      DPrep: begin
        // half the divisor added in for round to nearest, ties away from zero
        dvd_q <= (ttb_pkg::DvdW'(un_q) << ttb_pkg::QuotShift)
                 + ttb_pkg::DvdW'(ud_q >> 1);
      end
      DLoad: begin
        // quotient would need more than QuoW bits
        ovf_q <= ttb_pkg::DetW'(dvd_q[ttb_pkg::DvdW-1:ttb_pkg::QuoW]) >= ud_q;
        rem_q <= ttb_pkg::DetW'(dvd_q[ttb_pkg::DvdW-1:ttb_pkg::QuoW]);
        quo_q <= dvd_q[ttb_pkg::QuoW-1:0];
      end
      DRun: begin
        if (fits) begin
          rem_q <= ttb_pkg::DetW'(diff);
        end else begin
          rem_q <= ttb_pkg::DetW'(trial);
        end
        quo_q <= {quo_q[ttb_pkg::QuoW-2:0], fits};
      end
      default: begin
      end
    endcase
  end

  assign pos_big = ovf_q | quo_q[ttb_pkg::QuoW-1] | quo_q[ttb_pkg::OutW-1];
  assign neg_big = ovf_q | quo_q[ttb_pkg::QuoW-1]
                 | (quo_q[ttb_pkg::OutW-1] & (|quo_q[ttb_pkg::OutW-2:0]));

  always_comb begin
    if (neg_q) begin
      quot = neg_big ? ttb_pkg::OutMin : ttb_pkg::OutW'(0) - quo_q[ttb_pkg::OutW-1:0];
    end else begin
      quot = pos_big ? ttb_pkg::OutMax : quo_q[ttb_pkg::OutW-1:0];
    end
  end

  assign rsp_o.done = (state_q == DFin);
  assign rsp_o.quot = quot;

endmodule

>>> rtl/triangle_tangent_basis_core.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_core
// Takes triangle corners three at a time and returns the tangent and
// bitangent of each triangle in signed Q16.16 with saturation, plus the three
// vertex indices. The first and second corners are only stored. The third
// corner starts a run: one shared 25x17 multiplier forms the uv determinant
// and six numerators, each through states StMul1, StMul2 and StSub, and one
// restoring divider, one bit per cycle, turns each numerator into a rounded
// quotient. A zero uv determinant skips the divider and forces zero vectors.
// The input is not ready during that run. A finished result sits in the output
// register until taken, while the next triangle's corners come in.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ttb_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [ttb_pkg::PosW-1:0]   pos_y_i,
  input  logic signed [ttb_pkg::PosW-1:0]   pos_z_i,
  input  logic signed [ttb_pkg::TexW-1:0]   tex_s_i,
  input  logic signed [ttb_pkg::TexW-1:0]   tex_t_i,
  input  logic        [ttb_pkg::IdxW-1:0]   vertex_index_i,
  input  logic                              end_of_mesh_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ttb_pkg::OutW-1:0]   tangent_x_o,
  output logic signed [ttb_pkg::OutW-1:0]   tangent_y_o,
  output logic signed [ttb_pkg::OutW-1:0]   tangent_z_o,
  output logic signed [ttb_pkg::OutW-1:0]   bitangent_x_o,
  output logic signed [ttb_pkg::OutW-1:0]   bitangent_y_o,
  output logic signed [ttb_pkg::OutW-1:0]   bitangent_z_o,
  output logic                              degenerate_o,
  output logic        [ttb_pkg::IdxW-1:0]   index_first_o,
  output logic        [ttb_pkg::IdxW-1:0]   index_second_o,
  output logic        [ttb_pkg::IdxW-1:0]   index_third_o,
  output logic                              last_triangle_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StSub  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  localparam logic [ttb_pkg::OpW-1:0] OpDet  = 3'd0;
  localparam logic [ttb_pkg::OpW-1:0] OpTanX = 3'd1;
  localparam logic [ttb_pkg::OpW-1:0] OpTanY = 3'd2;
  localparam logic [ttb_pkg::OpW-1:0] OpTanZ = 3'd3;
  localparam logic [ttb_pkg::OpW-1:0] OpBitX = 3'd4;
  localparam logic [ttb_pkg::OpW-1:0] OpBitY = 3'd5;
  localparam logic [ttb_pkg::OpW-1:0] OpBitZ = 3'd6;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic [1:0] LastCorner = 2'd2;

  logic [2:0]                        state_q, state_d;
  logic [1:0]                        corner_cnt_q;
  logic [ttb_pkg::OpW-1:0]           op_q, op_d;
  logic                              out_valid_q;

  logic signed [ttb_pkg::PosW-1:0]   held_x_q [2];
  logic signed [ttb_pkg::PosW-1:0]   held_y_q [2];
  logic signed [ttb_pkg::PosW-1:0]   held_z_q [2];
  logic signed [ttb_pkg::TexW-1:0]   held_s_q [2];
  logic signed [ttb_pkg::TexW-1:0]   held_t_q [2];
  logic        [ttb_pkg::IdxW-1:0]   held_idx_q [2];

  logic signed [ttb_pkg::DtW-1:0]    du1_q, dv1_q, du2_q, dv2_q;
  logic signed [ttb_pkg::DpW-1:0]    dp1_q [3];
  logic signed [ttb_pkg::DpW-1:0]    dp2_q [3];
  logic        [ttb_pkg::IdxW-1:0]   idx3_q;
  logic                              last_q;

  logic signed [ttb_pkg::NumW-1:0]   acc_q;
  logic signed [ttb_pkg::DetW-1:0]   det_q;
  logic                              degen_q;
  logic        [ttb_pkg::OutW-1:0]   res_q [ttb_pkg::NumRes];

  logic signed [ttb_pkg::OutW-1:0]   tx_q, ty_q, tz_q, bx_q, by_q, bz_q;
  logic                              degen_out_q;
  logic        [ttb_pkg::IdxW-1:0]   idx0_out_q, idx1_out_q, idx2_out_q;
  logic                              last_out_q;

  logic                              in_fire;
  logic                              slot;
  logic                              first;
  logic [1:0]                        axis;
  logic signed [ttb_pkg::DpW-1:0]    mul_a;
  logic signed [ttb_pkg::DtW-1:0]    mul_b;
  logic signed [ttb_pkg::ProdW-1:0]  prod;
  logic signed [ttb_pkg::NumW-1:0]   num;
  logic [ttb_pkg::OpW-1:0]           res_slot;
  logic                              advance;
  logic                              out_load;
  ttb_pkg::div_req_t                 div_req;
  ttb_pkg::div_rsp_t                 div_rsp;

  assign in_fire  = in_valid_i && (state_q == StIdle);
  assign slot     = corner_cnt_q[0];
  assign first    = (state_q == StMul1);
  assign num      = acc_q - ttb_pkg::NumW'(prod);
  assign res_slot = op_q - 1'b1;
  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);
  assign advance  = ((state_q == StSub) && ((op_q == OpDet) || degen_q))
                 || ((state_q == StDiv) && div_rsp.done);

  // operand pairs: det = du1*dv2 - dv1*du2, t = d1*dv2 - d2*dv1, b = d2*du1 - d1*du2
  always_comb begin
    unique case (op_q) inside
      OpTanX, OpBitX: axis = AxisX;
      OpTanY, OpBitY: axis = AxisY;
      OpTanZ, OpBitZ: axis = AxisZ;
      default:        axis = AxisX;
    endcase
  end

  always_comb begin
    unique case (op_q) inside
      OpDet: begin
        mul_a = first ? ttb_pkg::DpW'(du1_q) : ttb_pkg::DpW'(dv1_q);
        mul_b = first ? dv2_q : du2_q;
      end
      OpTanX, OpTanY, OpTanZ: begin
        mul_a = first ? dp1_q[axis] : dp2_q[axis];
        mul_b = first ? dv2_q : dv1_q;
      end
      OpBitX, OpBitY, OpBitZ: begin
        mul_a = first ? dp2_q[axis] : dp1_q[axis];
        mul_b = first ? du1_q : du2_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ttb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign div_req.start = (state_q == StSub) && (op_q != OpDet) && !degen_q;
  assign div_req.num   = num;
  assign div_req.den   = det_q;

  ttb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    if (advance) begin
      op_d = op_q + 1'b1;
    end
    unique case (state_q)
      StIdle: begin
        if (in_fire && (corner_cnt_q == LastCorner)) begin
          state_d = StMul1;
          op_d    = OpDet;
        end
      end
      StMul1: state_d = StMul2;
      StMul2: state_d = StSub;
      StSub: begin
        if (op_q == OpDet) begin
          state_d = StMul1;
        end else if (degen_q) begin
          state_d = (op_q == OpBitZ) ? StOut : StMul1;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          state_d = (op_q == OpBitZ) ? StOut : StMul1;
        end
      end
      StOut: if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      op_q         <= OpDet;
      corner_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (in_fire) begin
        corner_cnt_q <= (corner_cnt_q == LastCorner) ? 2'd0 : corner_cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (corner_cnt_q != LastCorner) begin
        held_x_q[slot]   <= pos_x_i;
        held_y_q[slot]   <= pos_y_i;
        held_z_q[slot]   <= pos_z_i;
        held_s_q[slot]   <= tex_s_i;
        held_t_q[slot]   <= tex_t_i;
        held_idx_q[slot] <= vertex_index_i;
      end else begin
        du1_q    <= ttb_pkg::DtW'(held_s_q[1]) - ttb_pkg::DtW'(held_s_q[0]);
        dv1_q    <= ttb_pkg::DtW'(held_t_q[1]) - ttb_pkg::DtW'(held_t_q[0]);
        du2_q    <= ttb_pkg::DtW'(tex_s_i) - ttb_pkg::DtW'(held_s_q[0]);
        dv2_q    <= ttb_pkg::DtW'(tex_t_i) - ttb_pkg::DtW'(held_t_q[0]);
        dp1_q[0] <= ttb_pkg::DpW'(held_x_q[1]) - ttb_pkg::DpW'(held_x_q[0]);
        dp1_q[1] <= ttb_pkg::DpW'(held_y_q[1]) - ttb_pkg::DpW'(held_y_q[0]);
        dp1_q[2] <= ttb_pkg::DpW'(held_z_q[1]) - ttb_pkg::DpW'(held_z_q[0]);
        dp2_q[0] <= ttb_pkg::DpW'(pos_x_i) - ttb_pkg::DpW'(held_x_q[0]);
        dp2_q[1] <= ttb_pkg::DpW'(pos_y_i) - ttb_pkg::DpW'(held_y_q[0]);
        dp2_q[2] <= ttb_pkg::DpW'(pos_z_i) - ttb_pkg::DpW'(held_z_q[0]);
        idx3_q   <= vertex_index_i;
        last_q   <= end_of_mesh_i;
      end
    end

    if (state_q == StMul2) begin
      acc_q <= ttb_pkg::NumW'(prod);
    end

    if ((state_q == StSub) && (op_q == OpDet)) begin
      det_q   <= ttb_pkg::DetW'(num);
      degen_q <= (num == '0);
    end

    // zero determinant: vectors forced to zero, divider skipped
    if ((state_q == StSub) && (op_q != OpDet) && degen_q) begin
      res_q[res_slot] <= '0;
    end else if ((state_q == StDiv) && div_rsp.done) begin
      res_q[res_slot] <= div_rsp.quot;
    end

    if (out_load) begin
      tx_q        <= res_q[0];
      ty_q        <= res_q[1];
      tz_q        <= res_q[2];
      bx_q        <= res_q[3];
      by_q        <= res_q[4];
      bz_q        <= res_q[5];
      degen_out_q <= degen_q;
      idx0_out_q  <= held_idx_q[0];
      idx1_out_q  <= held_idx_q[1];
      idx2_out_q  <= idx3_q;
      last_out_q  <= last_q;
    end
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_valid_q;
  assign tangent_x_o     = tx_q;
  assign tangent_y_o     = ty_q;
  assign tangent_z_o     = tz_q;
  assign bitangent_x_o   = bx_q;
  assign bitangent_y_o   = by_q;
  assign bitangent_z_o   = bz_q;
  assign degenerate_o    = degen_out_q;
  assign index_first_o   = idx0_out_q;
  assign index_second_o  = idx1_out_q;
  assign index_third_o   = idx2_out_q;
  assign last_triangle_o = last_out_q;

endmodule

>>> rtl/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker
// port level checks of the triangle tangent basis core, bound to the top
// ----------------------------------------------------------------------------
`include "triangle_tangent_basis_core_assert.svh"

module ttb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [ttb_pkg::OutW-1:0] tangent_x_o,
  input logic signed [ttb_pkg::OutW-1:0] tangent_y_o,
  input logic signed [ttb_pkg::OutW-1:0] tangent_z_o,
  input logic signed [ttb_pkg::OutW-1:0] bitangent_x_o,
  input logic signed [ttb_pkg::OutW-1:0] bitangent_y_o,
  input logic signed [ttb_pkg::OutW-1:0] bitangent_z_o,
  input logic                            degenerate_o,
  input logic        [ttb_pkg::IdxW-1:0] index_first_o
);

  logic [1:0] cnt_q;
  logic       in_fire;
  logic       third_fire;
  logic       vec_zero;

  assign in_fire    = in_valid_i && in_ready_o;
  assign third_fire = in_fire && (cnt_q == 2'd2);
  assign vec_zero   = (tangent_x_o == '0) && (tangent_y_o == '0) && (tangent_z_o == '0)
                   && (bitangent_x_o == '0) && (bitangent_y_o == '0)
                   && (bitangent_z_o == '0);

  // corner position within the triangle, seen from the input transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_fire) begin
      cnt_q <= third_fire ? 2'd0 : cnt_q + 1'b1;
    end
  end

  `TTB_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(tangent_x_o) && $stable(bitangent_z_o) && $stable(index_first_o), "stalled result changed")
  `TTB_ASSERT(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o |-> vec_zero, "degenerate result with nonzero vectors")
  `TTB_ASSERT(a_busy_after_third, clk_i, rst_ni, third_fire |=> !in_ready_o, "input still ready after third corner")
  `TTB_ASSERT(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o), "result without a computation run")
  `TTB_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind triangle_tangent_basis_core ttb_checker u_ttb_checker (.*);

>>> tb/triangle_tangent_basis_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tangent_basis_core_tb
// Sends triangle corners in groups of three and checks each tangent and
// bitangent result against a fixed point model in the bench or values typed
// into the table. Its hand-picked triangles come first: the unit triangle,
// degenerate uv sets, saturation both ways and the extremes of every field.
// Random triangles follow in phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_core_tb;

  localparam int TriPerPhase = 162;
  localparam int DrainCycles = 300;
  localparam int StuckLimit  = 20000;

  typedef struct packed {
    logic signed [ttb_pkg::PosW-1:0] px;
    logic signed [ttb_pkg::PosW-1:0] py;
    logic signed [ttb_pkg::PosW-1:0] pz;
    logic signed [ttb_pkg::TexW-1:0] ts;
    logic signed [ttb_pkg::TexW-1:0] tt;
    logic        [ttb_pkg::IdxW-1:0] idx;
    logic                            eom;
  } corner_t;

  typedef struct packed {
    logic [ttb_pkg::OutW-1:0] tan_x;
    logic [ttb_pkg::OutW-1:0] tan_y;
    logic [ttb_pkg::OutW-1:0] tan_z;
    logic [ttb_pkg::OutW-1:0] bit_x;
    logic [ttb_pkg::OutW-1:0] bit_y;
    logic [ttb_pkg::OutW-1:0] bit_z;
    logic                     degen;
    logic [ttb_pkg::IdxW-1:0] idx_first;
    logic [ttb_pkg::IdxW-1:0] idx_second;
    logic [ttb_pkg::IdxW-1:0] idx_third;
    logic                     last;
  } basis_t;

  typedef struct packed {
    corner_t c;
    logic    typed;
    basis_t  want;
  } row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic signed [ttb_pkg::PosW-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [ttb_pkg::TexW-1:0] tex_s_i, tex_t_i;
  logic        [ttb_pkg::IdxW-1:0] vertex_index_i;
  logic                            end_of_mesh_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic signed [ttb_pkg::OutW-1:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic signed [ttb_pkg::OutW-1:0] bitangent_x_o, bitangent_y_o, bitangent_z_o;
  logic                            degenerate_o;
  logic        [ttb_pkg::IdxW-1:0] index_first_o, index_second_o, index_third_o;
  logic                            last_triangle_o;

  triangle_tangent_basis_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .tex_s_i         (tex_s_i),
    .tex_t_i         (tex_t_i),
    .vertex_index_i  (vertex_index_i),
    .end_of_mesh_i   (end_of_mesh_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tangent_x_o     (tangent_x_o),
    .tangent_y_o     (tangent_y_o),
    .tangent_z_o     (tangent_z_o),
    .bitangent_x_o   (bitangent_x_o),
    .bitangent_y_o   (bitangent_y_o),
    .bitangent_z_o   (bitangent_z_o),
    .degenerate_o    (degenerate_o),
    .index_first_o   (index_first_o),
    .index_second_o  (index_second_o),
    .index_third_o   (index_third_o),
    .last_triangle_o (last_triangle_o)
  );

  // bench copy of the corner store
  longint                   held_pos [2][3];
  longint                   held_tex [2][2];
  logic [ttb_pkg::IdxW-1:0] held_idx [2];
  int                       corner_cnt;

  basis_t pending_basis [$];
  row_t   directed_rows [$];

  int errors;
  int corners_sent;
  int triangles_checked;
  int degen_seen;
  int sat_seen;
  int in_idle_pct;
  int out_stall_pct;
  int stuck_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // numerator * 2^20 / det, nearest with ties away from zero, saturated
  function automatic logic [ttb_pkg::OutW-1:0] round_q16(longint num, longint den);
    bit              neg;
    longint unsigned un, ud, q;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    q   = ((un << ttb_pkg::QuotShift) + ud / 2) / ud;
    if (!neg) return (q > 64'h7FFF_FFFF) ? ttb_pkg::OutMax : q[ttb_pkg::OutW-1:0];
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    q = 64'd0 - q;
    return q[ttb_pkg::OutW-1:0];
  endfunction

  // advances the corner store; returns 1 when the corner closes a triangle
  function automatic bit predict_corner(input corner_t c, output basis_t r);
    longint p [3];
    longint du1, dv1, du2, dv2, det, d1, d2;
    logic [ttb_pkg::OutW-1:0] tq [3];
    logic [ttb_pkg::OutW-1:0] bq [3];
    int k;
    p[0] = longint'($signed(c.px));
    p[1] = longint'($signed(c.py));
    p[2] = longint'($signed(c.pz));
    r = '0;
    if (corner_cnt < 2) begin
      for (k = 0; k < 3; k++) held_pos[corner_cnt][k] = p[k];
      held_tex[corner_cnt][0] = longint'($signed(c.ts));
      held_tex[corner_cnt][1] = longint'($signed(c.tt));
      held_idx[corner_cnt] = c.idx;
      corner_cnt++;
      return 1'b0;
    end
    corner_cnt = 0;
    du1 = held_tex[1][0] - held_tex[0][0];
    dv1 = held_tex[1][1] - held_tex[0][1];
    du2 = longint'($signed(c.ts)) - held_tex[0][0];
    dv2 = longint'($signed(c.tt)) - held_tex[0][1];
    det = du1 * dv2 - dv1 * du2;
    for (k = 0; k < 3; k++) begin
      d1 = held_pos[1][k] - held_pos[0][k];
      d2 = p[k] - held_pos[0][k];
      tq[k] = (det == 0) ? '0 : round_q16(d1 * dv2 - d2 * dv1, det);
      bq[k] = (det == 0) ? '0 : round_q16(d2 * du1 - d1 * du2, det);
    end
    r.tan_x      = tq[0];
    r.tan_y      = tq[1];
    r.tan_z      = tq[2];
    r.bit_x      = bq[0];
    r.bit_y      = bq[1];
    r.bit_z      = bq[2];
    r.degen      = (det == 0);
    r.idx_first  = held_idx[0];
    r.idx_second = held_idx[1];
    r.idx_third  = c.idx;
    r.last       = c.eom;
    return 1'b1;
  endfunction

  function automatic corner_t mk_corner(logic signed [ttb_pkg::PosW-1:0] px,
                                        logic signed [ttb_pkg::PosW-1:0] py,
                                        logic signed [ttb_pkg::PosW-1:0] pz,
                                        logic signed [ttb_pkg::TexW-1:0] ts,
                                        logic signed [ttb_pkg::TexW-1:0] tt,
                                        logic [ttb_pkg::IdxW-1:0] idx,
                                        logic eom);
    corner_t c;
    c.px  = px;
    c.py  = py;
    c.pz  = pz;
    c.ts  = ts;
    c.tt  = tt;
    c.idx = idx;
    c.eom = eom;
    return c;
  endfunction

  function automatic basis_t mk_basis(logic [ttb_pkg::OutW-1:0] tx,
                                      logic [ttb_pkg::OutW-1:0] ty,
                                      logic [ttb_pkg::OutW-1:0] tz,
                                      logic [ttb_pkg::OutW-1:0] bx,
                                      logic [ttb_pkg::OutW-1:0] by,
                                      logic [ttb_pkg::OutW-1:0] bz,
                                      logic degen, logic [ttb_pkg::IdxW-1:0] i0,
                                      logic [ttb_pkg::IdxW-1:0] i1,
                                      logic [ttb_pkg::IdxW-1:0] i2, logic last);
    basis_t b;
    b.tan_x      = tx;
    b.tan_y      = ty;
    b.tan_z      = tz;
    b.bit_x      = bx;
    b.bit_y      = by;
    b.bit_z      = bz;
    b.degen      = degen;
    b.idx_first  = i0;
    b.idx_second = i1;
    b.idx_third  = i2;
    b.last       = last;
    return b;
  endfunction

  task automatic add_row(corner_t c, logic typed, basis_t want);
    row_t r;
    r.c     = c;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  // min, max, zero, one or all ones at width w
  function automatic logic [ttb_pkg::PosW-1:0] extreme_value(int w);
    logic [ttb_pkg::PosW-1:0] v;
    case ($urandom_range(4))
      0:       v = 24'd1 << (w - 1);
      1:       v = (24'd1 << (w - 1)) - 24'd1;
      2:       v = '0;
      3:       v = 24'd1;
      default: v = (w == ttb_pkg::PosW) ? '1 : ((24'd1 << w) - 24'd1);
    endcase
    return v;
  endfunction

  task automatic send_corner(corner_t c, logic typed, basis_t want);
    basis_t calc;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pos_x_i        <= c.px;
    pos_y_i        <= c.py;
    pos_z_i        <= c.pz;
    tex_s_i        <= c.ts;
    tex_t_i        <= c.tt;
    vertex_index_i <= c.idx;
    end_of_mesh_i  <= c.eom;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_corner(c, calc)) pending_basis.push_back(typed ? want : calc);
    corners_sent++;
  endtask

  task automatic send_triangle();
    corner_t                  c [3];
    int                       mode, k;
    logic [ttb_pkg::TexW-1:0] ds, dt;
    mode = $urandom_range(99);
    for (k = 0; k < 3; k++) begin
      c[k].px  = 24'($urandom);
      c[k].py  = 24'($urandom);
      c[k].pz  = 24'($urandom);
      c[k].ts  = 16'($urandom);
      c[k].tt  = 16'($urandom);
      c[k].idx = 16'($urandom);
      c[k].eom = ($urandom_range(9) == 0);
    end
    if (mode >= 40 && mode < 70) begin
      // compact triangle, the usual mesh case
      for (k = 1; k < 3; k++) begin
        c[k].px = c[0].px + 24'($urandom_range(8191)) - 24'd4096;
        c[k].py = c[0].py + 24'($urandom_range(8191)) - 24'd4096;
        c[k].pz = c[0].pz + 24'($urandom_range(8191)) - 24'd4096;
        c[k].ts = c[0].ts + 16'($urandom_range(4095)) - 16'd2048;
        c[k].tt = c[0].tt + 16'($urandom_range(4095)) - 16'd2048;
      end
    end else if (mode >= 70 && mode < 80) begin
      // collinear or coincident uvs
      ds = 16'($urandom_range(1200)) - 16'd600;
      dt = 16'($urandom_range(1200)) - 16'd600;
      if ($urandom_range(1) == 0) begin
        ds = '0;
        dt = '0;
      end
      c[1].ts = c[0].ts + ds;
      c[1].tt = c[0].tt + dt;
      c[2].ts = c[0].ts + (ds << 1);
      c[2].tt = c[0].tt + (dt << 1);
    end else if (mode >= 80 && mode < 90) begin
      // tiny determinant drives the outputs into saturation
      for (k = 1; k < 3; k++) begin
        c[k].ts = c[0].ts + 16'($urandom_range(4)) - 16'd2;
        c[k].tt = c[0].tt + 16'($urandom_range(4)) - 16'd2;
      end
    end else if (mode >= 90) begin
      for (k = 0; k < 3; k++) begin
        c[k].px = extreme_value(ttb_pkg::PosW);
        c[k].py = extreme_value(ttb_pkg::PosW);
        c[k].pz = extreme_value(ttb_pkg::PosW);
        c[k].ts = 16'(extreme_value(ttb_pkg::TexW));
        c[k].tt = 16'(extreme_value(ttb_pkg::TexW));
        c[k].idx = ($urandom_range(1) == 0) ? '0 : '1;
      end
    end
    for (k = 0; k < 3; k++) send_corner(c[k], 1'b0, '0);
  endtask

  task automatic compare_field(string name, logic [ttb_pkg::OutW-1:0] want,
                               logic [ttb_pkg::OutW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_basis();
    basis_t want, got;
    got = mk_basis(tangent_x_o, tangent_y_o, tangent_z_o, bitangent_x_o, bitangent_y_o,
                   bitangent_z_o, degenerate_o, index_first_o, index_second_o,
                   index_third_o, last_triangle_o);
    if (pending_basis.size() == 0) begin
      $display("%0t: result transaction with no triangle pending", $time);
      errors++;
    end else begin
      want = pending_basis.pop_front();
      compare_field("tangent_x", want.tan_x, got.tan_x);
      compare_field("tangent_y", want.tan_y, got.tan_y);
      compare_field("tangent_z", want.tan_z, got.tan_z);
      compare_field("bitangent_x", want.bit_x, got.bit_x);
      compare_field("bitangent_y", want.bit_y, got.bit_y);
      compare_field("bitangent_z", want.bit_z, got.bit_z);
      compare_field("degenerate", 32'(want.degen), 32'(got.degen));
      compare_field("index_first", 32'(want.idx_first), 32'(got.idx_first));
      compare_field("index_second", 32'(want.idx_second), 32'(got.idx_second));
      compare_field("index_third", 32'(want.idx_third), 32'(got.idx_third));
      compare_field("last_triangle", 32'(want.last), 32'(got.last));
      triangles_checked++;
      if (want.degen) degen_seen++;
      if (want.tan_x inside {ttb_pkg::OutMax, ttb_pkg::OutMin} ||
          want.tan_y inside {ttb_pkg::OutMax, ttb_pkg::OutMin} ||
          want.tan_z inside {ttb_pkg::OutMax, ttb_pkg::OutMin} ||
          want.bit_x inside {ttb_pkg::OutMax, ttb_pkg::OutMin} ||
          want.bit_y inside {ttb_pkg::OutMax, ttb_pkg::OutMin} ||
          want.bit_z inside {ttb_pkg::OutMax, ttb_pkg::OutMin})
        sat_seen++;
    end
  endtask

  // result side: random stalls and checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      if (out_valid_o && out_ready_i) check_basis();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int i, ph, t;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    pos_z_i        = '0;
    tex_s_i        = '0;
    tex_t_i        = '0;
    vertex_index_i = '0;
    end_of_mesh_i  = 1'b0;
    errors            = 0;
    corners_sent      = 0;
    triangles_checked = 0;
    degen_seen        = 0;
    sat_seen          = 0;
    in_idle_pct       = 0;
    out_stall_pct     = 0;
    stuck_cycles      = 0;
    corner_cnt        = 0;

    // unit triangle: tangent along x, bitangent along y, both 1.0
    add_row(mk_corner(0, 0, 0, 0, 0, 16'd0, 1'b0), 1'b0, '0);
    add_row(mk_corner(256, 0, 0, 4096, 0, 16'd1, 1'b0), 1'b0, '0);
    add_row(mk_corner(0, 256, 0, 0, 4096, 16'd2, 1'b0), 1'b1,
            mk_basis(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 1'b0, 16'd0, 16'd1, 16'd2,
                     1'b0));
    // coincident uvs, end mark on the first two corners only
    add_row(mk_corner(24'h123456, 24'hABCDEF, 24'h000100, 16'h1234, 16'hEDCB, 16'd10, 1'b1),
            1'b0, '0);
    add_row(mk_corner(24'h654321, 24'h00FF00, 24'hFFFF00, 16'h1234, 16'hEDCB, 16'd11, 1'b1),
            1'b0, '0);
    add_row(mk_corner(24'h0F0F0F, 24'h7F0000, 24'h800001, 16'h1234, 16'hEDCB, 16'd12, 1'b0),
            1'b1, mk_basis(0, 0, 0, 0, 0, 0, 1'b1, 16'd10, 16'd11, 16'd12, 1'b0));
    // collinear uvs on the final triangle of a mesh
    add_row(mk_corner(24'h000400, 24'h000800, 24'hFFF000, 0, 0, 16'hFFFF, 1'b0), 1'b0, '0);
    add_row(mk_corner(24'h001400, 24'h100800, 24'hFF0000, 4096, 4096, 16'h8000, 1'b0),
            1'b0, '0);
    add_row(mk_corner(24'h300400, 24'h000000, 24'h0F0000, 8192, 8192, 16'h7FFF, 1'b1), 1'b1,
            mk_basis(0, 0, 0, 0, 0, 0, 1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1));
    // det of one with the widest x span: tangent x clips high
    add_row(mk_corner(24'h800000, 0, 0, 0, 0, 16'd20, 1'b0), 1'b0, '0);
    add_row(mk_corner(24'h7FFFFF, 0, 0, 1, 0, 16'd21, 1'b0), 1'b0, '0);
    add_row(mk_corner(24'h800000, 0, 0, 0, 1, 16'd22, 1'b0), 1'b1,
            mk_basis(ttb_pkg::OutMax, 0, 0, 0, 0, 0, 1'b0, 16'd20, 16'd21, 16'd22, 1'b0));
    // same span reversed: tangent x clips low, bitangent y clips high
    add_row(mk_corner(24'h7FFFFF, 0, 0, 0, 0, 16'd30, 1'b0), 1'b0, '0);
    add_row(mk_corner(24'h800000, 0, 0, 1, 0, 16'd31, 1'b0), 1'b0, '0);
    add_row(mk_corner(24'h7FFFFF, 24'h7FFFFF, 0, 0, 1, 16'd32, 1'b0), 1'b1,
            mk_basis(ttb_pkg::OutMin, 0, 0, 0, ttb_pkg::OutMax, 0, 1'b0, 16'd30, 16'd31,
                     16'd32, 1'b0));
    // uv and position extremes together
    add_row(mk_corner(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 16'h8000, 16'h7FFF, 16'hAAAA, 1'b0),
            1'b0, '0);
    add_row(mk_corner(24'h800000, 24'h7FFFFF, 24'h000001, 16'h7FFF, 16'h8000, 16'h5555, 1'b1),
            1'b0, '0);
    add_row(mk_corner(24'h000000, 24'hFFFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0),
            1'b0, '0);
    // small odd determinant, negative deltas, fractional results
    add_row(mk_corner(3, -5, 7, 0, 0, 16'd100, 1'b0), 1'b0, '0);
    add_row(mk_corner(-2, 9, 1, 3, -1, 16'd200, 1'b0), 1'b0, '0);
    add_row(mk_corner(5, 5, -4, -2, 7, 16'd300, 1'b1), 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < directed_rows.size(); i++)
      send_corner(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 59;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 59;
        end
        default: begin
          in_idle_pct   = 8;
          out_stall_pct = 8;
        end
      endcase
      for (t = 0; t < TriPerPhase; t++) send_triangle();
      if (ph == 1) begin
        // hold off until the block has handed back everything
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_basis.size() != 0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_basis.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d corners, checked %0d triangles", corners_sent, triangles_checked);
    $display("of those %0d had a zero uv determinant and %0d a clipped component",
             degen_seen, sat_seen);
    if (errors == 0 && pending_basis.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> triangle_tangent_basis_core.f
+incdir+rtl
rtl/ttb_pkg.sv
rtl/ttb_mul.sv
rtl/ttb_div.sv
rtl/triangle_tangent_basis_core.sv
rtl/ttb_checker.sv
tb/triangle_tangent_basis_core_tb.sv
